// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mpfd_pkg.sv -----
// ----------------------------------------------------------------------------
// mpfd_pkg
// Types and constants of the page-mode framebuffer draw engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpfd_pkg;

  localparam int PANEL_WIDTH_DEF  = 128;
  localparam int PANEL_HEIGHT_DEF = 64;

  typedef enum logic [2:0] {
    REQ_CLEAR   = 3'd0,
    REQ_PIXEL   = 3'd1,
    REQ_HLINE   = 3'd2,
    REQ_VLINE   = 3'd3,
    REQ_OUTLINE = 3'd4,
    REQ_FILLED  = 3'd5,
    REQ_READ    = 3'd6
  } req_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_CALC,
    ST_RD,
    ST_WR,
    ST_RDREQ,
    ST_RDDATA,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] mask;
  } pix_info_t;

endpackage

// ----- src/mpfd_mem.sv -----
// ----------------------------------------------------------------------------
// mpfd_mem
// Frame store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpfd_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/mpfd_pix.sv -----
// ----------------------------------------------------------------------------
// mpfd_pix
// Pixel unit: panel bounds check, store address and bit mask of one pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpfd_pix
  import mpfd_pkg::*;
#(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
  parameter int AW           = 10
) (
  input  logic [7:0]    px,
  input  logic [7:0]    py,
  output pix_info_t     info,
  output logic [AW-1:0] addr
);

  logic [13:0] page_base;
  logic [13:0] sum;

  assign page_base = 14'(py[7:3]) * 14'(PANEL_WIDTH);
  assign sum       = page_base + 14'(px);
  assign addr      = AW'(sum);

  assign info.ok   = ({1'b0, px} < 9'(PANEL_WIDTH)) && ({1'b0, py} < 9'(PANEL_HEIGHT));
  assign info.mask = 8'd1 << py[2:0];

endmodule

// ----- src/mono_page_framebuffer_draw.sv -----
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw
// Drawing engine for a 1-bpp page-organized frame store.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel, one transfer each; every request returns
// exactly one 8-bit transfer on the m_ channel (the store byte for a read,
// zero otherwise). s_tready is high only while the engine is idle.
// Each on-panel pixel goes through the shared pixel unit (address and bounds),
// a store read and an OR-write; an off-panel pixel is checked and skipped.
// Filled rectangles are drawn column by column.
// Clear sweeps the store one byte a cycle, PANEL_WIDTH*ceil(PANEL_HEIGHT/8)
// bytes in all (1024 by default); after reset the same sweep runs before the
// first request is taken.
// A finished result waits in the output register; a new request may be taken
// meanwhile, and the engine holds its next result until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mono_page_framebuffer_draw
  import mpfd_pkg::*;
#(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // x_start, y_start, x_end, y_end, line_length, read_index, pad
  input  logic [2:0]  s_tuser,  // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata   // read_data
);

  localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
  localparam int AW          = $clog2(STORE_BYTES);

  state_t state, state_next;

  req_t       op;
  logic [7:0] xs, ys, xe, ye, ln, len8, hgt8, col;
  logic [1:0] seg;
  logic [8:0] cnt;
  logic [7:0] mask_q, rslt;
  logic       ri_ok;
  logic [AW-1:0] addr_q;

  logic [7:0] in_xs, in_xe, in_ys, in_ye, in_len;
  logic [9:0] in_ri;
  req_t       in_req;
  logic       accept;

  logic [7:0] seg_bx, seg_by;
  logic       seg_vert, seg_last;
  logic [8:0] seg_len;
  logic       seg_done;
  logic [7:0] px, py;

  pix_info_t     pix;
  logic [AW-1:0] pix_addr;

  logic       mem_we;
  logic [7:0] mem_wdata, mem_rdata;
  logic       out_free;

  assign in_req = req_t'(s_tuser);
  assign in_xs  = s_tdata[7:0];
  assign in_ys  = s_tdata[15:8];
  assign in_xe  = s_tdata[23:16];
  assign in_ye  = s_tdata[31:24];
  assign in_ri  = s_tdata[49:40];
  assign in_len = in_xe - in_xs + 8'd1;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    seg_bx   = xs;
    seg_by   = ys;
    seg_vert = 1'b0;
    seg_len  = 9'd0;
    seg_last = 1'b1;
    case (op)
      REQ_PIXEL: begin
        seg_len = 9'd1;
      end
      REQ_HLINE: begin
        seg_len = {1'b0, ln};
      end
      REQ_VLINE: begin
        seg_vert = 1'b1;
        seg_len  = {1'b0, ln};
      end
      REQ_OUTLINE: begin
        seg_last = (seg == 2'd3);
        case (seg)
          2'd0: begin
            seg_len = {1'b0, len8};
          end
          2'd1: begin
            seg_by  = ye;
            seg_len = {1'b0, len8};
          end
          2'd2: begin
            seg_vert = 1'b1;
            seg_len  = {1'b0, hgt8};
          end
          default: begin
            seg_bx   = xe;
            seg_vert = 1'b1;
            seg_len  = {1'b0, hgt8};
          end
        endcase
      end
      REQ_FILLED: begin
        seg_bx   = xs + col;
        seg_vert = 1'b1;
        seg_len  = {1'b0, hgt8} + 9'd1;
        seg_last = (col == len8 - 8'd1);
      end
      default: begin
        seg_len = 9'd0;
      end
    endcase
  end

  assign seg_done = (cnt >= seg_len);
  assign px = seg_bx + (seg_vert ? 8'd0 : cnt[7:0]);
  assign py = seg_by + (seg_vert ? cnt[7:0] : 8'd0);

  mpfd_pix #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .AW           (AW)
  ) u_pix (
    .px   (px),
    .py   (py),
    .info (pix),
    .addr (pix_addr)
  );

  mpfd_mem #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr_q),
    .wdata (mem_wdata),
    .raddr (addr_q),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (addr_q == AW'(STORE_BYTES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_req)
            REQ_CLEAR: state_next = ST_CLEAR;
            REQ_READ:  state_next = ST_RDREQ;
            REQ_PIXEL, REQ_HLINE, REQ_VLINE, REQ_OUTLINE: state_next = ST_CALC;
            REQ_FILLED: state_next = (in_len == 8'd0) ? ST_RESP : ST_CALC;
            default:   state_next = ST_RESP;
          endcase
        end
      end
      ST_CLEAR: begin
        if (addr_q == AW'(STORE_BYTES - 1)) begin
          state_next = ST_RESP;
        end
      end
      ST_CALC: begin
        if (seg_done) begin
          if (seg_last) begin
            state_next = ST_RESP;
          end
        end else if (pix.ok) begin
          state_next = ST_RD;
        end
      end
      ST_RD:     state_next = ST_WR;
      ST_WR:     state_next = ST_CALC;
      ST_RDREQ:  state_next = ST_RDDATA;
      ST_RDDATA: state_next = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = 8'd0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_INIT, ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata | mask_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      addr_q   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_RESP && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_INIT, ST_CLEAR: begin
          addr_q <= addr_q + AW'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            op     <= in_req;
            xs     <= in_xs;
            ys     <= in_ys;
            xe     <= in_xe;
            ye     <= in_ye;
            ln     <= s_tdata[39:32];
            len8   <= in_len;
            hgt8   <= in_ye - in_ys;
            seg    <= 2'd0;
            col    <= 8'd0;
            cnt    <= 9'd0;
            rslt   <= 8'd0;
            ri_ok  <= (16'(in_ri) < 16'(STORE_BYTES));
            addr_q <= (in_req == REQ_CLEAR) ? '0 : AW'(in_ri);
          end
        end
        ST_CALC: begin
          if (seg_done) begin
            if (!seg_last) begin
              seg <= seg + 2'd1;
              col <= col + 8'd1;
              cnt <= 9'd0;
            end
          end else if (pix.ok) begin
            addr_q <= pix_addr;
            mask_q <= pix.mask;
          end else begin
            cnt <= cnt + 9'd1;
          end
        end
        ST_WR: begin
          cnt <= cnt + 9'd1;
        end
        ST_RDDATA: begin
          rslt <= ri_ok ? mem_rdata : 8'd0;
        end
        ST_RESP: begin
          if (out_free) begin
            m_tdata <= rslt;
          end
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

  `ASSERT_IMPL(a_we_state, mem_we, (state == ST_INIT || state == ST_CLEAR || state == ST_WR), "store write outside sweep or write step")
  `ASSERT_IMPL(a_wr_after_rd, (state == ST_WR), ($past(state) == ST_RD), "write step not preceded by read step")
  `ASSERT_NEXT(a_accept_busy, accept, (state != ST_IDLE), "engine idle after accepting a request")
  `ASSERT_NEXT(a_resp_load, (state == ST_RESP && out_free), (m_tvalid && state == ST_IDLE), "result not loaded on free output")

endmodule

// ----- tb/sv/tb_mono_page_framebuffer_draw.sv -----
// ----------------------------------------------------------------------------
// tb_mono_page_framebuffer_draw
// Self-checking bench for the page-mode 1-bpp framebuffer draw engine.
// A directed table goes first: reads after reset, corner pixels, off-panel
// pixels, wrapping lines and rectangles, the unused request code and clear.
// Random requests follow. They are biased toward the panel and toward bytes
// that were recently drawn, and run in three traffic phases. A behavioral
// copy of the frame store predicts each response byte that the table does not
// fix, and each m_ transfer is compared against the oldest expected byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mono_page_framebuffer_draw;
  import mpfd_pkg::*;

  localparam int PANEL_W     = PANEL_WIDTH_DEF;
  localparam int PANEL_H     = PANEL_HEIGHT_DEF;
  localparam int STORE_BYTES = PANEL_W * ((PANEL_H + 7) / 8);
  localparam int SCRIPT_LEN  = 23;
  localparam int PHASE_ITEMS = 510;
  localparam int DRAIN_WAIT  = 64;
  localparam int STALL_LIMIT = 300000;
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] xs;
    logic [7:0] ys;
    logic [7:0] xe;
    logic [7:0] ye;
    logic [7:0] len;
    logic [9:0] idx;
  } draw_req_t;

  typedef struct packed {
    draw_req_t  rq;
    logic       known;
    logic [7:0] want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  logic [7:0] frame_model [STORE_BYTES];
  logic [9:0] recent_bytes [$];
  logic [7:0] pending_bytes [$];
  logic [7:0] head_byte;
  int         fails = 0;
  int         sender_idle_pct = 0;
  int         receiver_stall_pct = 0;
  int         quiet_cycles = 0;

  // kind, xs, ys, xe, ye, len, idx ; known ; want
  script_row_t script [SCRIPT_LEN] = '{
    '{'{REQ_READ,    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   10'd0},    1'b1, 8'h00},
    '{'{REQ_READ,    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   10'd1023}, 1'b1, 8'h00},
    '{'{REQ_PIXEL,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   10'd0},    1'b1, 8'h00},
    '{'{REQ_READ,    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   10'd0},    1'b1, 8'h01},
    '{'{REQ_PIXEL,   8'd127, 8'd63,  8'd0,   8'd0,   8'd0,   10'd0},    1'b1, 8'h00},
    '{'{REQ_READ,    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   10'd1023}, 1'b1, 8'h80},
    '{'{REQ_PIXEL,   8'd128, 8'd0,   8'd0,   8'd0,   8'd0,   10'd0},    1'b1, 8'h00},
    '{'{REQ_PIXEL,   8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   10'd0},    1'b1, 8'h00},
    '{'{REQ_HLINE,   8'd250, 8'd10,  8'd0,   8'd0,   8'd20,  10'd0},    1'b1, 8'h00},
    '{'{REQ_READ,    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   10'd130},  1'b0, 8'h00},
    '{'{REQ_VLINE,   8'd5,   8'd60,  8'd0,   8'd0,   8'd255, 10'd0},    1'b1, 8'h00},
    '{'{REQ_READ,    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   10'd901},  1'b0, 8'h00},
    '{'{REQ_HLINE,   8'd40,  8'd40,  8'd0,   8'd0,   8'd0,   10'd0},    1'b1, 8'h00},
    '{'{REQ_OUTLINE, 8'd10,  8'd5,   8'd20,  8'd30,  8'd0,   10'd0},    1'b1, 8'h00},
    '{'{REQ_OUTLINE, 8'd120, 8'd50,  8'd3,   8'd2,   8'd0,   10'd0},    1'b1, 8'h00},
    '{'{REQ_FILLED,  8'd30,  8'd8,   8'd33,  8'd12,  8'd0,   10'd0},    1'b1, 8'h00},
    '{'{REQ_FILLED,  8'd200, 8'd100, 8'd199, 8'd100, 8'd0,   10'd0},    1'b1, 8'h00},
    '{'{REQ_READ,    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   10'd159},  1'b0, 8'h00},
    '{'{REQ_UNUSED,  8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 10'd1023}, 1'b1, 8'h00},
    '{'{REQ_READ,    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   10'd10},   1'b0, 8'h00},
    '{'{REQ_CLEAR,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   10'd0},    1'b1, 8'h00},
    '{'{REQ_READ,    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   10'd0},    1'b1, 8'h00},
    '{'{REQ_READ,    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   10'd1023}, 1'b1, 8'h00}
  };

  mono_page_framebuffer_draw dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void paint_pixel(logic [7:0] x, logic [7:0] y);
    int idx;
    if (x >= PANEL_W || y >= PANEL_H) return;
    idx = int'(x) + int'(y >> 3) * PANEL_W;
    if (idx >= STORE_BYTES) return;
    frame_model[idx] = frame_model[idx] | (8'd1 << y[2:0]);
    recent_bytes.push_back(10'(idx));
    if (recent_bytes.size() > 32) void'(recent_bytes.pop_front());
  endfunction

  function automatic logic [7:0] draw_predict(draw_req_t rq);
    logic [7:0] width;
    logic [7:0] height;
    logic [7:0] rd;
    rd = 8'h00;
    width = rq.xe - rq.xs + 8'd1;
    height = rq.ye - rq.ys;
    case (rq.kind)
      REQ_CLEAR: begin
        foreach (frame_model[i]) frame_model[i] = 8'h00;
      end
      REQ_PIXEL: paint_pixel(rq.xs, rq.ys);
      REQ_HLINE: begin
        for (int i = 0; i < rq.len; i++) paint_pixel(rq.xs + 8'(i), rq.ys);
      end
      REQ_VLINE: begin
        for (int i = 0; i < rq.len; i++) paint_pixel(rq.xs, rq.ys + 8'(i));
      end
      REQ_OUTLINE: begin
        for (int i = 0; i < width; i++) begin
          paint_pixel(rq.xs + 8'(i), rq.ys);
          paint_pixel(rq.xs + 8'(i), rq.ye);
        end
        for (int i = 0; i < height; i++) begin
          paint_pixel(rq.xs, rq.ys + 8'(i));
          paint_pixel(rq.xe, rq.ys + 8'(i));
        end
      end
      REQ_FILLED: begin
        for (int i = 0; i < width; i++)
          for (int j = 0; j <= height; j++) paint_pixel(rq.xs + 8'(i), rq.ys + 8'(j));
      end
      REQ_READ: begin
        if (rq.idx < STORE_BYTES) rd = frame_model[rq.idx];
      end
      default: ;
    endcase
    return rd;
  endfunction

  // hold valid across back-to-back requests; drop it only in idle cycles
  task automatic issue(input draw_req_t rq, input logic known, input logic [7:0] want);
    logic [7:0] predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, rq.idx, rq.len, rq.ye, rq.xe, rq.ys, rq.xs};
    s_tuser  <= rq.kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = draw_predict(rq);
    pending_bytes.push_back(known ? want : predicted);
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_bytes.size() == 0) begin
        $error("read_data: unexpected transfer, expected none, actual %02h", m_tdata);
        fails++;
      end else begin
        head_byte = pending_bytes.pop_front();
        if (m_tdata !== head_byte) begin
          $error("read_data: expected %02h, actual %02h", head_byte, m_tdata);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    draw_req_t rq;
    int        pick;
    foreach (frame_model[i]) frame_model[i] = 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct    = (phase == 0) ? 23 : (phase == 1) ? 88 : 0;
      receiver_stall_pct = (phase == 0) ? 88 : (phase == 1) ? 23 : 0;
      if (phase == 0) begin
        for (int r = 0; r < SCRIPT_LEN; r++) issue(script[r].rq, script[r].known, script[r].want);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick    = $urandom_range(99);
        rq.xs   = 8'($urandom);
        rq.ys   = 8'($urandom);
        rq.xe   = 8'($urandom);
        rq.ye   = 8'($urandom);
        rq.len  = 8'($urandom);
        rq.idx  = 10'($urandom);
        rq.kind = (pick < 3)  ? REQ_CLEAR   : (pick < 5)  ? REQ_UNUSED :
                  (pick < 20) ? REQ_PIXEL   : (pick < 35) ? REQ_HLINE  :
                  (pick < 50) ? REQ_VLINE   : (pick < 60) ? REQ_OUTLINE :
                  (pick < 69) ? REQ_FILLED  : REQ_READ;
        if (rq.kind inside {REQ_PIXEL, REQ_HLINE, REQ_VLINE, REQ_OUTLINE, REQ_FILLED}) begin
          if ($urandom_range(4) != 0) begin
            rq.xs = 8'($urandom_range(135));
            rq.ys = 8'($urandom_range(71));
          end
        end
        if (rq.kind inside {REQ_HLINE, REQ_VLINE} && $urandom_range(3) != 0)
          rq.len = 8'($urandom_range(40));
        if (rq.kind == REQ_OUTLINE && $urandom_range(1) == 0) begin
          rq.xe = rq.xs + 8'($urandom_range(20));
          rq.ye = rq.ys + 8'($urandom_range(20));
        end
        // keep most filled rectangles small; a full-range one is slow
        if (rq.kind == REQ_FILLED && $urandom_range(499) != 0) begin
          rq.xe = rq.xs + 8'($urandom_range(15));
          rq.ye = rq.ys + 8'($urandom_range(15));
        end
        if (rq.kind == REQ_READ && recent_bytes.size() > 0 && $urandom_range(1) == 0)
          rq.idx = recent_bytes[$urandom_range(recent_bytes.size() - 1)];
        issue(rq, 1'b0, 8'h00);
      end
      // hold off until every response has drained
      s_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- mono_page_framebuffer_draw.f -----
+incdir+src
src/mpfd_pkg.sv
src/mpfd_mem.sv
src/mpfd_pix.sv
src/mono_page_framebuffer_draw.sv
tb/sv/tb_mono_page_framebuffer_draw.sv
